### hdl/ipidc_pkg.sv
`timescale 1ns / 1ps

package ipidc_pkg;

    // Widest data word that the configuration port carries.
    localparam int unsigned BUS_W  = 32;
    localparam int unsigned ADDR_W = 5;
    localparam int unsigned IDX_W  = 3;

    // Register indexes on the configuration port.
    localparam logic [IDX_W-1:0] REG_GAIN_PROP  = 3'd0;
    localparam logic [IDX_W-1:0] REG_GAIN_INTEG = 3'd1;
    localparam logic [IDX_W-1:0] REG_GAIN_DERIV = 3'd2;
    localparam logic [IDX_W-1:0] REG_DELTA_MAX  = 3'd3;
    localparam logic [IDX_W-1:0] REG_DELTA_MIN  = 3'd4;
    localparam logic [IDX_W-1:0] REG_DRIVE_MAX  = 3'd5;
    localparam logic [IDX_W-1:0] REG_DRIVE_MIN  = 3'd6;
    localparam logic [IDX_W-1:0] REG_DIRECTION  = 3'd7;

    // Item actions.
    localparam logic ACT_UPDATE = 1'b0;
    localparam logic ACT_CLEAR  = 1'b1;

    // Drive directions.
    localparam logic DIR_ADD = 1'b0;
    localparam logic DIR_SUB = 1'b1;

    // Limit status codes.
    localparam logic [1:0] ST_WITHIN = 2'd0;
    localparam logic [1:0] ST_AT_MAX = 2'd1;
    localparam logic [1:0] ST_AT_MIN = 2'd2;

    // Configuration as seen by the datapath, sign-extended to the bus width.
    typedef struct packed {
        logic signed [BUS_W-1:0] gain_prop;
        logic signed [BUS_W-1:0] gain_integ;
        logic signed [BUS_W-1:0] gain_deriv;
        logic signed [BUS_W-1:0] delta_max;
        logic signed [BUS_W-1:0] delta_min;
        logic signed [BUS_W-1:0] drive_max;
        logic signed [BUS_W-1:0] drive_min;
        logic                    direction;
    } t_cfg;

endpackage

### hdl/ipidc_regs.sv
`timescale 1ns / 1ps

module ipidc_regs #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ipidc_pkg::ADDR_W-1:0]      paddr,
    input  logic [ipidc_pkg::BUS_W-1:0]       pwdata,
    output logic [ipidc_pkg::BUS_W-1:0]       prdata,
    output logic                              pready,
    output ipidc_pkg::t_cfg                   o_cfg
);

    localparam int W = DATA_WIDTH;

    logic [W-1:0] r_gain_prop;
    logic [W-1:0] r_gain_integ;
    logic [W-1:0] r_gain_deriv;
    logic [W-1:0] r_delta_max;
    logic [W-1:0] r_delta_min;
    logic [W-1:0] r_drive_max;
    logic [W-1:0] r_drive_min;
    logic         r_direction;

    logic                          wr_en;
    logic [ipidc_pkg::IDX_W-1:0]   reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ipidc_pkg::ADDR_W-1:2];
    assign wr_en   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_prop  <= '0;
            r_gain_integ <= '0;
            r_gain_deriv <= '0;
            r_delta_max  <= {1'b0, {(W-1){1'b1}}};
            r_delta_min  <= {1'b1, {(W-1){1'b0}}};
            r_drive_max  <= '0;
            r_drive_min  <= '0;
            r_direction  <= ipidc_pkg::DIR_ADD;
        end else if (wr_en) begin
            unique case (reg_idx)
                ipidc_pkg::REG_GAIN_PROP:  r_gain_prop  <= pwdata[W-1:0];
                ipidc_pkg::REG_GAIN_INTEG: r_gain_integ <= pwdata[W-1:0];
                ipidc_pkg::REG_GAIN_DERIV: r_gain_deriv <= pwdata[W-1:0];
                ipidc_pkg::REG_DELTA_MAX:  r_delta_max  <= pwdata[W-1:0];
                ipidc_pkg::REG_DELTA_MIN:  r_delta_min  <= pwdata[W-1:0];
                ipidc_pkg::REG_DRIVE_MAX:  r_drive_max  <= pwdata[W-1:0];
                ipidc_pkg::REG_DRIVE_MIN:  r_drive_min  <= pwdata[W-1:0];
                ipidc_pkg::REG_DIRECTION:  r_direction  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            ipidc_pkg::REG_GAIN_PROP:  prdata = ipidc_pkg::BUS_W'(r_gain_prop);
            ipidc_pkg::REG_GAIN_INTEG: prdata = ipidc_pkg::BUS_W'(r_gain_integ);
            ipidc_pkg::REG_GAIN_DERIV: prdata = ipidc_pkg::BUS_W'(r_gain_deriv);
            ipidc_pkg::REG_DELTA_MAX:  prdata = ipidc_pkg::BUS_W'(r_delta_max);
            ipidc_pkg::REG_DELTA_MIN:  prdata = ipidc_pkg::BUS_W'(r_delta_min);
            ipidc_pkg::REG_DRIVE_MAX:  prdata = ipidc_pkg::BUS_W'(r_drive_max);
            ipidc_pkg::REG_DRIVE_MIN:  prdata = ipidc_pkg::BUS_W'(r_drive_min);
            ipidc_pkg::REG_DIRECTION:  prdata = ipidc_pkg::BUS_W'(r_direction);
            default:                   prdata = '0;
        endcase
    end

    assign o_cfg.gain_prop  = ipidc_pkg::BUS_W'($signed(r_gain_prop));
    assign o_cfg.gain_integ = ipidc_pkg::BUS_W'($signed(r_gain_integ));
    assign o_cfg.gain_deriv = ipidc_pkg::BUS_W'($signed(r_gain_deriv));
    assign o_cfg.delta_max  = ipidc_pkg::BUS_W'($signed(r_delta_max));
    assign o_cfg.delta_min  = ipidc_pkg::BUS_W'($signed(r_delta_min));
    assign o_cfg.drive_max  = ipidc_pkg::BUS_W'($signed(r_drive_max));
    assign o_cfg.drive_min  = ipidc_pkg::BUS_W'($signed(r_drive_min));
    assign o_cfg.direction  = r_direction;

endmodule

### hdl/ipidc_incr.sv
`timescale 1ns / 1ps

module ipidc_incr #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  ipidc_pkg::t_cfg            i_cfg,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_action,
    input  logic signed [DATA_WIDTH-1:0] i_target,
    input  logic signed [DATA_WIDTH-1:0] i_sample,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic                       o_action,
    output logic signed [DATA_WIDTH-1:0] o_delta
);

    localparam int W  = DATA_WIDTH;
    localparam int EW = W + 1;
    localparam int DW = W + 2;
    localparam int PW = 2 * W + 2;
    localparam int SW = 2 * W + 4;

    // Stage 0: input register.
    logic                 r_v0;
    logic                 r_act0;
    logic signed [W-1:0]  r_target0;
    logic signed [W-1:0]  r_sample0;
    // Stage 1: error.
    logic                 r_v1;
    logic                 r_act1;
    logic signed [EW-1:0] r_err1;
    // Stage 2: error differences.
    logic                 r_v2;
    logic                 r_act2;
    logic signed [EW-1:0] r_err2;
    logic signed [DW-1:0] r_diff_p2;
    logic signed [DW-1:0] r_diff_d2;
    // Stage 3: products.
    logic                 r_v3;
    logic                 r_act3;
    logic signed [PW-1:0] r_prod_p3;
    logic signed [PW-1:0] r_prod_i3;
    logic signed [PW-1:0] r_prod_d3;
    // Stage 4: clamped increment.
    logic                 r_v4;
    logic                 r_act4;
    logic signed [W-1:0]  r_delta4;
    // Error history.
    logic signed [EW-1:0] r_err_back1;
    logic signed [EW-1:0] r_err_back2;

    logic rdy0, rdy1, rdy2, rdy3, rdy4;
    logic mv1, mv2, mv3, mv4;

    logic signed [SW-1:0] sum;
    logic signed [SW-1:0] sum_max;
    logic signed [SW-1:0] sum_min;
    logic signed [W-1:0]  delta_clamped;

    assign rdy4 = !r_v4 || i_ready;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;
    assign rdy0 = !r_v0 || rdy1;

    assign mv1 = r_v0 && rdy1;
    assign mv2 = r_v1 && rdy2;
    assign mv3 = r_v2 && rdy3;
    assign mv4 = r_v3 && rdy4;

    assign o_stall = !rdy0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0        <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_err_back1 <= '0;
            r_err_back2 <= '0;
        end else begin
            if (rdy0) begin
                r_v0 <= i_valid;
            end
            if (rdy1) begin
                r_v1 <= r_v0;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
            if (rdy4) begin
                r_v4 <= r_v3;
            end
            if (mv2) begin
                if (r_act1 == ipidc_pkg::ACT_CLEAR) begin
                    r_err_back1 <= '0;
                    r_err_back2 <= '0;
                end else begin
                    r_err_back1 <= r_err1;
                    r_err_back2 <= r_err_back1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy0 && i_valid) begin
            r_act0    <= i_action;
            r_target0 <= i_target;
            r_sample0 <= i_sample;
        end
        if (mv1) begin
            r_act1 <= r_act0;
            r_err1 <= EW'(r_target0) - EW'(r_sample0);
        end
        if (mv2) begin
            r_act2    <= r_act1;
            r_err2    <= r_err1;
            r_diff_p2 <= DW'(r_err1) - DW'(r_err_back1);
            r_diff_d2 <= DW'(r_err1) - DW'(r_err_back2);
        end
        if (mv3) begin
            r_act3    <= r_act2;
            r_prod_p3 <= PW'($signed(i_cfg.gain_prop[W-1:0])) * PW'(r_diff_p2);
            r_prod_i3 <= PW'($signed(i_cfg.gain_integ[W-1:0])) * PW'(r_err2);
            r_prod_d3 <= PW'($signed(i_cfg.gain_deriv[W-1:0])) * PW'(r_diff_d2);
        end
        if (mv4) begin
            r_act4   <= r_act3;
            r_delta4 <= delta_clamped;
        end
    end

    always_comb begin
        sum     = SW'(r_prod_p3) + SW'(r_prod_i3) + SW'(r_prod_d3);
        sum_max = SW'($signed(i_cfg.delta_max[W-1:0]));
        sum_min = SW'($signed(i_cfg.delta_min[W-1:0]));
        if (sum > sum_max) begin
            delta_clamped = $signed(i_cfg.delta_max[W-1:0]);
        end else if (sum < sum_min) begin
            delta_clamped = $signed(i_cfg.delta_min[W-1:0]);
        end else begin
            delta_clamped = $signed(sum[W-1:0]);
        end
    end

    assign o_valid  = r_v4;
    assign o_action = r_act4;
    assign o_delta  = r_delta4;

endmodule

### hdl/ipidc_drive.sv
`timescale 1ns / 1ps

module ipidc_drive #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ipidc_pkg::t_cfg              i_cfg,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_action,
    input  logic signed [DATA_WIDTH-1:0] i_delta,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [DATA_WIDTH-1:0] o_drive,
    output logic [1:0]                   o_limit_status
);

    localparam int W  = DATA_WIDTH;
    localparam int FW = W + 1;

    // The stored drive is also the output register of the drive field.
    logic                r_valid;
    logic signed [W-1:0] r_drive;
    logic [1:0]          r_status;

    logic signed [W-1:0]  n_drive;
    logic [1:0]           n_status;
    logic signed [FW-1:0] f_sum;
    logic signed [FW-1:0] f_max;
    logic signed [FW-1:0] f_min;
    logic                 load;

    assign o_ready = !r_valid || !i_stall;
    assign load    = i_valid && o_ready;

    always_comb begin
        f_max = FW'($signed(i_cfg.drive_max[W-1:0]));
        f_min = FW'($signed(i_cfg.drive_min[W-1:0]));
        if (i_cfg.direction == ipidc_pkg::DIR_SUB) begin
            f_sum = FW'(r_drive) - FW'(i_delta);
        end else begin
            f_sum = FW'(r_drive) + FW'(i_delta);
        end
        if (i_action == ipidc_pkg::ACT_CLEAR) begin
            n_drive  = r_drive;
            n_status = ipidc_pkg::ST_WITHIN;
        end else if (f_sum >= f_max) begin
            n_drive  = $signed(i_cfg.drive_max[W-1:0]);
            n_status = ipidc_pkg::ST_AT_MAX;
        end else if (f_sum <= f_min) begin
            n_drive  = $signed(i_cfg.drive_min[W-1:0]);
            n_status = ipidc_pkg::ST_AT_MIN;
        end else begin
            n_drive  = f_sum[W-1:0];
            n_status = ipidc_pkg::ST_WITHIN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_drive <= '0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (load) begin
                r_drive <= n_drive;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_status <= n_status;
        end
    end

    assign o_valid        = r_valid;
    assign o_drive        = r_drive;
    assign o_limit_status = r_status;

endmodule

### hdl/incremental_pid_clamped.sv
`timescale 1ns / 1ps
// Channel   | Direction | Handshake          | Payload
// input     | in        | i_valid / o_stall  | i_action, i_target, i_sample
// result    | out       | o_valid / i_stall  | o_drive, o_limit_status
// config    | in        | APB psel / penable | paddr, pwdata, prdata
//
// One item is taken per cycle while o_stall is low; its result passes the input
// register and the error, difference, multiply, sum-and-clamp and drive stages.
// Reset is synchronous and active low; it empties the pipeline and clears the
// error history and the drive. A stalled result holds in the output register
// while empty stages upstream keep taking items.

module incremental_pid_clamped #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_action,
    input  logic signed [DATA_WIDTH-1:0]      i_target,
    input  logic signed [DATA_WIDTH-1:0]      i_sample,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [DATA_WIDTH-1:0]      o_drive,
    output logic [1:0]                        o_limit_status,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ipidc_pkg::ADDR_W-1:0]      paddr,
    input  logic [ipidc_pkg::BUS_W-1:0]       pwdata,
    output logic [ipidc_pkg::BUS_W-1:0]       prdata,
    output logic                              pready
);

    ipidc_pkg::t_cfg cfg;

    logic                         incr_valid;
    logic                         incr_ready;
    logic                         incr_action;
    logic signed [DATA_WIDTH-1:0] incr_delta;

    ipidc_regs #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ipidc_incr #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_incr (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_action (i_action),
        .i_target (i_target),
        .i_sample (i_sample),
        .o_valid  (incr_valid),
        .i_ready  (incr_ready),
        .o_action (incr_action),
        .o_delta  (incr_delta)
    );

    ipidc_drive #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_drive (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_valid        (incr_valid),
        .o_ready        (incr_ready),
        .i_action       (incr_action),
        .i_delta        (incr_delta),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_drive        (o_drive),
        .o_limit_status (o_limit_status)
    );

endmodule

### hdl/ipidc_check.sv
`timescale 1ns / 1ps

module ipidc_check #(
    parameter int DATA_WIDTH = 32
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_out_valid,
    input logic                  i_out_stall,
    input logic                  i_in_stall,
    input logic [DATA_WIDTH-1:0] i_drive,
    input logic [1:0]            i_limit_status
);

    // Reset empties the output and zeroes the drive.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && (i_drive == '0))
        else $error("reset did not clear the output");

    // A stalled result holds.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_drive)
            && $stable(i_limit_status))
        else $error("stalled result changed");

    // The drive only moves when a new result is presented.
    a_drive_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$stable(i_drive) |-> i_out_valid)
        else $error("drive changed without a result");

    // With the output register empty, the pipeline never holds off input.
    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> !i_in_stall)
        else $error("input stalled while output is empty");

endmodule

bind incremental_pid_clamped ipidc_check #(
    .DATA_WIDTH(DATA_WIDTH)
) u_ipidc_check (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_valid),
    .i_out_stall    (i_stall),
    .i_in_stall     (o_stall),
    .i_drive        (o_drive),
    .i_limit_status (o_limit_status)
);

### bench/incremental_pid_clamped_checker.sv
`timescale 1ns / 1ps

module incremental_pid_clamped_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic                           i_action,
    input  logic signed [31:0]             i_target,
    input  logic signed [31:0]             i_sample,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic signed [31:0]             i_drive,
    input  logic [1:0]                     i_limit_status,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ipidc_pkg::ADDR_W-1:0]   paddr,
    input  logic [ipidc_pkg::BUS_W-1:0]    pwdata,
    input  logic                           pready,
    output int                             o_fail_count,
    output int                             o_pending
);

    localparam logic signed [31:0] I32_MAX = 32'h7FFF_FFFF;
    localparam logic signed [31:0] I32_MIN = 32'h8000_0000;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic signed [31:0] drive;
        logic [1:0]         status;
    } t_drive_result;

    t_drive_result drive_queue[$];

    logic signed [31:0] gain_p;
    logic signed [31:0] gain_i;
    logic signed [31:0] gain_d;
    logic signed [31:0] dlt_max;
    logic signed [31:0] dlt_min;
    logic signed [31:0] drv_max;
    logic signed [31:0] drv_min;
    logic               dir_sel;
    logic signed [32:0] err_back1;
    logic signed [32:0] err_back2;
    logic signed [31:0] drive_now;
    int                 fail_count = 0;
    int                 outstanding = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = outstanding;

    task automatic note_mismatch(input string what, input longint want, input longint got);
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, what, want, got);
        end
    endtask

    task automatic advance_pid(input logic act, input logic signed [31:0] tgt,
                               input logic signed [31:0] smp, output t_drive_result res);
        logic signed [32:0] err;
        logic signed [33:0] d_prop;
        logic signed [33:0] d_deriv;
        logic signed [71:0] acc;
        logic signed [31:0] delta;
        logic signed [33:0] f;
        if (act == ipidc_pkg::ACT_CLEAR) begin
            err_back1  = '0;
            err_back2  = '0;
            res.status = ipidc_pkg::ST_WITHIN;
        end else begin
            err     = {tgt[31], tgt} - {smp[31], smp};
            d_prop  = {err[32], err} - {err_back1[32], err_back1};
            d_deriv = {err[32], err} - {err_back2[32], err_back2};
            acc     = gain_p * d_prop + gain_i * err + gain_d * d_deriv;
            err_back2 = err_back1;
            err_back1 = err;
            if (acc > dlt_max) begin
                delta = dlt_max;
            end else if (acc < dlt_min) begin
                delta = dlt_min;
            end else begin
                delta = acc[31:0];
            end
            if (dir_sel == ipidc_pkg::DIR_SUB) begin
                f = drive_now - delta;
            end else begin
                f = drive_now + delta;
            end
            if (f >= drv_max) begin
                drive_now  = drv_max;
                res.status = ipidc_pkg::ST_AT_MAX;
            end else if (f <= drv_min) begin
                drive_now  = drv_min;
                res.status = ipidc_pkg::ST_AT_MIN;
            end else begin
                drive_now  = f[31:0];
                res.status = ipidc_pkg::ST_WITHIN;
            end
        end
        res.drive = drive_now;
    endtask

    always @(posedge i_clk) begin : monitor
        t_drive_result want;
        t_drive_result next_res;
        if (!i_rst_n) begin
            gain_p    = '0;
            gain_i    = '0;
            gain_d    = '0;
            dlt_max   = I32_MAX;
            dlt_min   = I32_MIN;
            drv_max   = '0;
            drv_min   = '0;
            dir_sel   = ipidc_pkg::DIR_ADD;
            err_back1 = '0;
            err_back2 = '0;
            drive_now = '0;
            drive_queue.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[ipidc_pkg::ADDR_W-1:2])
                    ipidc_pkg::REG_GAIN_PROP:  gain_p  = pwdata;
                    ipidc_pkg::REG_GAIN_INTEG: gain_i  = pwdata;
                    ipidc_pkg::REG_GAIN_DERIV: gain_d  = pwdata;
                    ipidc_pkg::REG_DELTA_MAX:  dlt_max = pwdata;
                    ipidc_pkg::REG_DELTA_MIN:  dlt_min = pwdata;
                    ipidc_pkg::REG_DRIVE_MAX:  drv_max = pwdata;
                    ipidc_pkg::REG_DRIVE_MIN:  drv_min = pwdata;
                    ipidc_pkg::REG_DIRECTION:  dir_sel = pwdata[0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (drive_queue.size() == 0) begin
                    note_mismatch("unexpected result drive", 0, i_drive);
                end else begin
                    want = drive_queue.pop_front();
                    if (i_drive !== want.drive) begin
                        note_mismatch("drive", want.drive, i_drive);
                    end
                    if (i_limit_status !== want.status) begin
                        note_mismatch("limit_status", want.status, i_limit_status);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                advance_pid(i_action, i_target, i_sample, next_res);
                drive_queue.push_back(next_res);
            end
        end
        outstanding <= drive_queue.size();
    end

endmodule

### bench/incremental_pid_clamped_tb.sv
`timescale 1ns / 1ps

module incremental_pid_clamped_tb;

    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 50;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 200000;
    localparam logic signed [31:0] I32_MAX = 32'h7FFF_FFFF;
    localparam logic signed [31:0] I32_MIN = 32'h8000_0000;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_valid;
    logic                           o_stall;
    logic                           i_action;
    logic signed [31:0]             i_target;
    logic signed [31:0]             i_sample;
    logic                           o_valid;
    logic                           i_stall;
    logic signed [31:0]             o_drive;
    logic [1:0]                     o_limit_status;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [ipidc_pkg::ADDR_W-1:0]   paddr;
    logic [ipidc_pkg::BUS_W-1:0]    pwdata;
    logic [ipidc_pkg::BUS_W-1:0]    prdata;
    logic                           pready;

    int   fail_count;
    int   pending;
    int   sent_count = 0;
    int   cycles = 0;
    logic hold_off = 1'b0;
    logic no_idle = 1'b0;

    incremental_pid_clamped u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_action       (i_action),
        .i_target       (i_target),
        .i_sample       (i_sample),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_drive        (o_drive),
        .o_limit_status (o_limit_status),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    incremental_pid_clamped_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_action       (i_action),
        .i_target       (i_target),
        .i_sample       (i_sample),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_drive        (o_drive),
        .i_limit_status (o_limit_status),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(0, 5))
            0, 1: return $urandom;
            2: return 32'(int'($urandom_range(0, 40)) - 20);
            3: return 32'(int'($urandom_range(0, 200000)) - 100000);
            default: begin
                case ($urandom_range(0, 4))
                    0: return I32_MAX;
                    1: return I32_MIN;
                    2: return 32'sd0;
                    3: return -32'sd1;
                    default: return 32'sd1;
                endcase
            end
        endcase
    endfunction

    task automatic apb_write(input logic [ipidc_pkg::IDX_W-1:0] idx, input logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic program_pid(input logic signed [31:0] gp, gi, gd, dmx, dmn, fmx, fmn,
                               input logic dir);
        apb_write(ipidc_pkg::REG_GAIN_PROP, gp);
        apb_write(ipidc_pkg::REG_GAIN_INTEG, gi);
        apb_write(ipidc_pkg::REG_GAIN_DERIV, gd);
        apb_write(ipidc_pkg::REG_DELTA_MAX, dmx);
        apb_write(ipidc_pkg::REG_DELTA_MIN, dmn);
        apb_write(ipidc_pkg::REG_DRIVE_MAX, fmx);
        apb_write(ipidc_pkg::REG_DRIVE_MIN, fmn);
        apb_write(ipidc_pkg::REG_DIRECTION, {31'd0, dir});
    endtask

    task automatic send_item(input logic act, input logic signed [31:0] tgt,
                             input logic signed [31:0] smp);
        int gap;
        gap = (no_idle || hold_off) ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_action <= act;
        i_target <= tgt;
        i_sample <= smp;
        do @(posedge i_clk); while (o_stall);
        sent_count++;
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic draw_limits(output logic signed [31:0] hi, output logic signed [31:0] lo,
                               input int span);
        logic signed [31:0] a;
        logic signed [31:0] b;
        a = rand_word();
        b = rand_word();
        case ($urandom_range(0, 3))
            0: begin
                hi = I32_MAX;
                lo = I32_MIN;
            end
            1: begin
                hi = (a > b) ? a : b;
                lo = (a > b) ? b : a;
            end
            2: begin
                hi = 32'($urandom_range(0, span));
                lo = -32'($urandom_range(0, span));
            end
            default: begin
                hi = a;
                lo = b;
            end
        endcase
    endtask

    task automatic random_phase(input int count);
        logic signed [31:0] dmx;
        logic signed [31:0] dmn;
        logic signed [31:0] fmx;
        logic signed [31:0] fmn;
        logic signed [31:0] tgt;
        logic signed [31:0] smp;
        logic               act;
        draw_limits(dmx, dmn, 5000);
        draw_limits(fmx, fmn, 100000);
        program_pid(rand_word(), rand_word(), rand_word(), dmx, dmn, fmx, fmn,
                    $urandom_range(0, 1) ? ipidc_pkg::DIR_SUB : ipidc_pkg::DIR_ADD);
        no_idle = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < count; k++) begin
            act = ($urandom_range(0, 9) == 0) ? ipidc_pkg::ACT_CLEAR : ipidc_pkg::ACT_UPDATE;
            tgt = rand_word();
            smp = $urandom_range(0, 1) ? tgt + 32'(int'($urandom_range(0, 64)) - 32)
                                       : rand_word();
            send_item(act, tgt, smp);
        end
        wait_idle();
        no_idle = 1'b0;
    endtask

    initial begin : receiver
        int n;
        forever begin
            while (hold_off) begin
                i_stall <= 1'b1;
                @(posedge i_clk);
            end
            n = no_idle ? 0 : $urandom_range(0, 7);
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    initial begin : long_hold
        @(posedge i_clk);
        while (sent_count < HOLD_AT) @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("incremental_pid_clamped_tb NOT OK");
        $finish;
    end

    initial begin : stimulus
        i_rst_n  <= 1'b0;
        i_valid  <= 1'b0;
        i_action <= ipidc_pkg::ACT_UPDATE;
        i_target <= '0;
        i_sample <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: zero gains and both drive limits at zero.
        send_item(ipidc_pkg::ACT_UPDATE, 32'sd100, 32'sd40);
        send_item(ipidc_pkg::ACT_UPDATE, I32_MIN, I32_MAX);
        wait_idle();

        program_pid(32'sd1, 32'sd1, 32'sd1, I32_MAX, I32_MIN, I32_MAX, I32_MIN,
                    ipidc_pkg::DIR_ADD);
        send_item(ipidc_pkg::ACT_UPDATE, I32_MAX, I32_MIN);
        send_item(ipidc_pkg::ACT_UPDATE, I32_MIN, I32_MAX);
        send_item(ipidc_pkg::ACT_UPDATE, 32'sd0, 32'sd0);
        send_item(ipidc_pkg::ACT_CLEAR, I32_MAX, I32_MIN);
        send_item(ipidc_pkg::ACT_UPDATE, 32'sd12, 32'sd5);
        send_item(ipidc_pkg::ACT_UPDATE, -32'sd7, 32'sd30);
        send_item(ipidc_pkg::ACT_UPDATE, I32_MAX, I32_MAX);
        wait_idle();

        program_pid(I32_MIN, I32_MIN, I32_MAX, 32'sd1000, -32'sd1000, 32'sd5000, -32'sd5000,
                    ipidc_pkg::DIR_SUB);
        send_item(ipidc_pkg::ACT_UPDATE, I32_MAX, I32_MIN);
        send_item(ipidc_pkg::ACT_UPDATE, I32_MIN, I32_MAX);
        send_item(ipidc_pkg::ACT_UPDATE, 32'sd1, 32'sd0);
        send_item(ipidc_pkg::ACT_UPDATE, 32'sd0, 32'sd1);
        send_item(ipidc_pkg::ACT_CLEAR, 32'sd0, 32'sd0);
        send_item(ipidc_pkg::ACT_UPDATE, I32_MAX, I32_MIN);
        wait_idle();

        // Inverted delta limits and inverted drive limits.
        program_pid(32'sd0, 32'sd1, 32'sd0, -32'sd50, 32'sd50, -32'sd10, 32'sd10,
                    ipidc_pkg::DIR_ADD);
        send_item(ipidc_pkg::ACT_UPDATE, 32'sd1000, 32'sd0);
        send_item(ipidc_pkg::ACT_UPDATE, -32'sd1000, 32'sd0);
        send_item(ipidc_pkg::ACT_UPDATE, 32'sd0, 32'sd0);
        send_item(ipidc_pkg::ACT_UPDATE, 32'sd3, 32'sd0);
        send_item(ipidc_pkg::ACT_UPDATE, -32'sd3, 32'sd0);
        wait_idle();

        for (int p = 0; p < PHASES; p++) begin
            random_phase(PHASE_ITEMS);
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("incremental_pid_clamped_tb OK");
        end else begin
            $display("incremental_pid_clamped_tb NOT OK");
        end
        $finish;
    end

endmodule
